// ===== src/ondt_pkg.sv =====
// Shared types and constants for the octree node dedup table.
`default_nettype none
package ondt_pkg;
  localparam int CHILDREN = 8;
  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;
  localparam logic [31:0] HASH_K = 32'h9e3779b9;

  typedef logic [15:0] child_t;
  typedef child_t [CHILDREN-1:0] node_t;

  // one hash round
  function automatic logic [31:0] hash_round(input logic [31:0] h, input child_t c);
    hash_round = h ^ ({16'd0, c} + HASH_K + (h << 6) + (h >> 2));
  endfunction
endpackage
`default_nettype wire

// ===== src/ondt_front.sv =====
// Front end: checks for the empty node, hashes the node with one mixing round per child.
`default_nettype none
module ondt_front
  import ondt_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  input  wire  node_t node_in,
  output logic busy,
  output logic q_valid,
  output logic q_empty,
  output logic [31:0] q_hash,
  output node_t q_node,
  input  wire  q_take
);
  logic [2:0] round;
  logic       hashing;
  logic [31:0] h;
  node_t      node;

  assign busy = hashing || q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hashing <= 1'b0;
      q_valid <= 1'b0;
      round   <= 3'd0;
    end else begin
      if (q_take) q_valid <= 1'b0;
      if (start && !busy) begin
        node <= node_in;
        h    <= 32'd0;
        round <= 3'd0;
        if (node_in == {CHILDREN{EMPTY_MARK}}) begin
          q_valid <= 1'b1;
          q_empty <= 1'b1;
          q_node  <= node_in;
        end else begin
          hashing <= 1'b1;
        end
      end else if (hashing) begin
        h     <= hash_round(h, node[round]);
        round <= round + 3'd1;
        if (round == 3'd7) begin
          hashing <= 1'b0;
          q_valid <= 1'b1;
          q_empty <= 1'b0;
          q_hash  <= hash_round(h, node[round]);
          q_node  <= node;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ondt_back.sv =====
// Back end: bucket clear after reset, bucket probe, entry compare, append and reference counting.
`default_nettype none
module ondt_back
  import ondt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HASH_BUCKETS  = 8192
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  q_valid,
  input  wire  q_empty,
  input  wire  [31:0] q_hash,
  input  wire  node_t q_node,
  output logic q_take,
  output logic done,
  output logic [15:0] node_index,
  output logic was_found,
  output logic table_full
);
  localparam int BW = $clog2(HASH_BUCKETS);
  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int SW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = $clog2(HASH_BUCKETS + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_RDB = 7'b0000100,
    S_CHKB = 7'b0001000, S_CMP = 7'b0010000, S_CNT = 7'b0100000,
    S_WCNT = 7'b1000000
  } state_t;
  state_t state;

  logic [SW-1:0] bucket_mem [HASH_BUCKETS];
  node_t         entry_mem  [TABLE_ENTRIES];
  logic [15:0]   count_mem  [TABLE_ENTRIES];

  logic [BW-1:0] b, clr;
  logic [PW-1:0] probes;
  logic [SW-1:0] used, slot_rd;
  node_t         ent_rd, node;
  logic [15:0]   cnt_rd;
  logic [EW-1:0] idx;
  logic          append;

  // bucket write port
  logic          bw_en;
  logic [BW-1:0] bw_addr;
  logic [SW-1:0] bw_data;

  // empty bucket found and room left in the entry store
  assign append = (state == S_CHKB) && (slot_rd == '0) && (used < SW'(TABLE_ENTRIES));

  always_comb begin
    bw_en = 1'b0; bw_addr = b; bw_data = SW'(used + SW'(1));
    if (state == S_CLEAR) begin bw_en = 1'b1; bw_addr = clr; bw_data = '0; end
    else if (state == S_CHKB && slot_rd == '0 && used < SW'(TABLE_ENTRIES))
      bw_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (bw_en) bucket_mem[bw_addr] <= bw_data;
    slot_rd <= bucket_mem[b];
  end
  always_ff @(posedge clk) begin
    if (append) entry_mem[used[EW-1:0]] <= node;
    ent_rd <= entry_mem[idx];
  end
  always_ff @(posedge clk) begin
    if (append) count_mem[used[EW-1:0]] <= 16'd1;
    else if (state == S_WCNT && cnt_rd != 16'hFFFF) count_mem[idx] <= cnt_rd + 16'd1;
    cnt_rd <= count_mem[idx];
  end

  assign q_take    = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + BW'(1);
          if (clr == BW'(HASH_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          node <= q_node;
          b <= BW'(q_hash % HASH_BUCKETS);
          probes <= '0;
          if (q_empty) begin
            done <= 1'b1; node_index <= EMPTY_MARK;
            was_found <= 1'b0; table_full <= 1'b0;
          end else state <= S_RDB;
        end
        S_RDB: state <= S_CHKB;
        S_CHKB: begin
          if (slot_rd == '0) begin
            done <= 1'b1; was_found <= 1'b0; state <= S_IDLE;
            if (used < SW'(TABLE_ENTRIES)) begin
              node_index <= 16'(used); table_full <= 1'b0; used <= used + SW'(1);
            end else begin
              node_index <= EMPTY_MARK; table_full <= 1'b1;
            end
          end else begin
            idx   <= EW'(slot_rd - SW'(1));
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_CNT; // entry read latency
        S_CNT: begin
          if (ent_rd == node) state <= S_WCNT;
          else begin
            probes <= probes + PW'(1);
            b <= (b == BW'(HASH_BUCKETS - 1)) ? '0 : b + BW'(1);
            if (probes == PW'(HASH_BUCKETS - 1)) begin
              done <= 1'b1; node_index <= EMPTY_MARK;
              was_found <= 1'b0; table_full <= 1'b1; state <= S_IDLE;
            end else state <= S_RDB;
          end
        end
        S_WCNT: begin
          done <= 1'b1; node_index <= 16'(idx);
          was_found <= 1'b1; table_full <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/octree_node_dedup_table.sv =====
// Octree node dedup table: hash-consing store for eight-child octree nodes.
// An item is taken when start is high and busy low; its one result appears for
// a single cycle with done high and cannot be held off. The front hashes with
// one mixing round per child; the back then reads a bucket, and for every
// occupied bucket it visits it reads the entry, compares it, then moves on to
// either the next bucket or the count update. An empty node skips the hash and
// the probe. The front is free again once the back has taken its item. After
// reset the back clears the bucket memory, one bucket a cycle, before results
// flow.
`default_nettype none
module octree_node_dedup_table
  import ondt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HASH_BUCKETS  = 8192
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  start,
  output logic busy,
  input  wire  [15:0] child_0,
  input  wire  [15:0] child_1,
  input  wire  [15:0] child_2,
  input  wire  [15:0] child_3,
  input  wire  [15:0] child_4,
  input  wire  [15:0] child_5,
  input  wire  [15:0] child_6,
  input  wire  [15:0] child_7,
  output logic done,
  output logic [15:0] node_index,
  output logic was_found,
  output logic table_full
);
  node_t node_in, q_node;
  logic q_valid, q_empty, q_take;
  logic [31:0] q_hash;

  assign node_in = {child_7, child_6, child_5, child_4,
                    child_3, child_2, child_1, child_0};

  ondt_front u_front (
    .clk, .rst, .start, .node_in, .busy,
    .q_valid, .q_empty, .q_hash, .q_node, .q_take
  );

  ondt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .HASH_BUCKETS(HASH_BUCKETS)) u_back (
    .clk, .rst, .q_valid, .q_empty, .q_hash, .q_node, .q_take,
    .done, .node_index, .was_found, .table_full
  );
endmodule
`default_nettype wire

// ===== dv/tb_octree_node_dedup_table.sv =====
// Testbench for the octree node dedup table: directed and random nodes against a local table model.
`timescale 1ns / 100ps
`default_nettype none
module tb_octree_node_dedup_table;
  import ondt_pkg::*;

  localparam int TABLE_ENTRIES = 4096;
  localparam int HASH_BUCKETS  = 8192;
  localparam int IDLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [15:0] node_index;
    logic        was_found;
    logic        table_full;
  } lookup_res_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] child_0, child_1, child_2, child_3, child_4, child_5, child_6, child_7;
  logic        done;
  logic [15:0] node_index;
  logic        was_found;
  logic        table_full;

  octree_node_dedup_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .HASH_BUCKETS (HASH_BUCKETS)
  ) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .child_0(child_0), .child_1(child_1), .child_2(child_2), .child_3(child_3),
    .child_4(child_4), .child_5(child_5), .child_6(child_6), .child_7(child_7),
    .done(done), .node_index(node_index), .was_found(was_found), .table_full(table_full)
  );

  // model of the table
  node_t       model_nodes [TABLE_ENTRIES];
  logic [15:0] model_refs  [TABLE_ENTRIES];
  int unsigned model_slots [HASH_BUCKETS];
  int unsigned model_used;

  lookup_res_t expected_q[$];
  node_t       sent_nodes[$];
  int          error_count;
  int          idle_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned bucket_of(node_t n);
    logic [31:0] h;
    h = 32'd0;
    for (int i = 0; i < CHILDREN; i++)
      h = h ^ ({16'd0, n[i]} + 32'h9e3779b9 + (h << 6) + (h >> 2));
    return h % HASH_BUCKETS;
  endfunction

  function automatic lookup_res_t insert_node(node_t n);
    lookup_res_t r;
    int unsigned b;
    int unsigned idx;
    r = '{node_index: EMPTY_MARK, was_found: 1'b0, table_full: 1'b0};
    if (n == {CHILDREN{EMPTY_MARK}}) return r;
    b = bucket_of(n);
    for (int p = 0; p < HASH_BUCKETS; p++) begin
      if (model_slots[b] == 0) begin
        if (model_used >= TABLE_ENTRIES) begin
          r.table_full = 1'b1;
          return r;
        end
        idx = model_used;
        model_nodes[idx] = n;
        model_refs[idx]  = 16'd1;
        model_slots[b]   = idx + 1;
        model_used       = idx + 1;
        r.node_index     = idx[15:0];
        return r;
      end
      idx = model_slots[b] - 1;
      if (model_nodes[idx] == n) begin
        if (model_refs[idx] != 16'hFFFF) model_refs[idx] = model_refs[idx] + 16'd1;
        r.node_index = idx[15:0];
        r.was_found  = 1'b1;
        return r;
      end
      b = (b + 1) % HASH_BUCKETS;
    end
    r.table_full = 1'b1;
    return r;
  endfunction

  // one transfer; called and returning at a rising edge
  task automatic send_node(node_t n);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    child_0 <= n[0]; child_1 <= n[1]; child_2 <= n[2]; child_3 <= n[3];
    child_4 <= n[4]; child_5 <= n[5]; child_6 <= n[6]; child_7 <= n[7];
    do @(posedge clk); while (busy);
    expected_q = {expected_q, insert_node(n)};
    sent_nodes = {sent_nodes, n};
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic node_t random_node();
    node_t n;
    for (int i = 0; i < CHILDREN; i++) begin
      case ($urandom_range(0, 3))
        0:       n[i] = EMPTY_MARK;
        1:       n[i] = 16'($urandom_range(0, 15));
        default: n[i] = 16'($urandom());
      endcase
    end
    return n;
  endfunction

  task automatic test_empty_node();
    send_node({CHILDREN{EMPTY_MARK}});
    send_node({CHILDREN{EMPTY_MARK}});
  endtask

  task automatic test_extremes();
    node_t n;
    send_node({CHILDREN{16'h0000}});
    send_node({CHILDREN{16'h0000}});
    send_node({CHILDREN{16'hFFFE}});
    n = {CHILDREN{EMPTY_MARK}};
    for (int i = 0; i < CHILDREN; i++) begin
      n[i] = 16'h0000;
      send_node(n);
      n[i] = EMPTY_MARK;
    end
    send_node({16'h0001, 16'h0002, 16'h0004, 16'h0008,
               16'h0010, 16'h0020, 16'h0040, 16'h8000});
    send_node({CHILDREN{16'hFFFE}});
    n = {CHILDREN{EMPTY_MARK}};
    n[7] = 16'h0000;
    send_node(n);
  endtask

  task automatic test_random(int count);
    node_t n;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0:          n = {CHILDREN{EMPTY_MARK}};
        1, 2, 3, 4: n = sent_nodes[$urandom_range(0, sent_nodes.size() - 1)];
        default:    n = random_node();
      endcase
      send_node(n);
      if (k == count / 2) wait_drained();
    end
  endtask

  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: idx %h found %b full %b",
                 $time, node_index, was_found, table_full);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (node_index !== want.node_index) begin
          $display("%0t: node_index expected %h actual %h", $time, want.node_index, node_index);
          error_count++;
        end
        if (was_found !== want.was_found) begin
          $display("%0t: was_found expected %b actual %b", $time, want.was_found, was_found);
          error_count++;
        end
        if (table_full !== want.table_full) begin
          $display("%0t: table_full expected %b actual %b", $time, want.table_full, table_full);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer and no result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    {child_0, child_1, child_2, child_3} = '0;
    {child_4, child_5, child_6, child_7} = '0;
    error_count = 0;
    idle_cycles = 0;
    model_used = 0;
    for (int i = 0; i < HASH_BUCKETS; i++) model_slots[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_node();
    test_extremes();
    test_random(934);
    wait_drained();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
src/ondt_pkg.sv
src/ondt_front.sv
src/ondt_back.sv
src/octree_node_dedup_table.sv
dv/tb_octree_node_dedup_table.sv
